// ===== src/slir_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slir_pkg: shared types and codes of the sorted list block
// Command codes and the control and status bundles passed along the cells.
// ----------------------------------------------------------------------------
package slir_pkg;

   localparam int CMD_W   = 2;
   localparam int DATA_W  = 32;
   localparam int INDEX_W = 5;
   localparam int COUNT_W = 6;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

   // broadcast to every cell
   typedef struct packed {
      logic              do_ins;
      logic              do_rem;
      logic [DATA_W-1:0] value;
   } cell_ctl_type;

   // seen by the neighbors and the top level
   typedef struct packed {
      logic [DATA_W-1:0] entry;
      logic              valid;
      logic              lt;   // value sorts before this entry, or slot empty
      logic              lo;   // entry sorts before value
      logic              hit;  // entry equals value
   } cell_stat_type;

endpackage

// ===== src/slir_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slir_cell: one slot of the sorted list
// Holds one entry and its valid bit; shifts up on insert, down on remove.
// ----------------------------------------------------------------------------
module slir_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  slir_pkg::cell_ctl_type ctl,
   input  slir_pkg::cell_stat_type left,
   input  slir_pkg::cell_stat_type right,
   output slir_pkg::cell_stat_type stat
);

   logic [slir_pkg::DATA_W-1:0] entry_ff, entry_in;
   logic                        valid_ff, valid_in;

   always_comb begin
      stat.entry = entry_ff;
      stat.valid = valid_ff;
      stat.lt    = !valid_ff || ($signed(ctl.value) < $signed(entry_ff));
      stat.lo    = valid_ff && ($signed(entry_ff) < $signed(ctl.value));
      stat.hit   = valid_ff && (entry_ff == ctl.value);
   end

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (ctl.do_ins && stat.lt) begin
         // take the left entry, or the new value at the insertion point
         entry_in = left.lt ? left.entry : ctl.value;
         valid_in = left.valid;
      end else if (ctl.do_rem && !stat.lo) begin
         entry_in = right.entry;
         valid_in = right.valid;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

// ===== src/sorted_list_insert_remove.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_insert_remove: ascending list of signed values
// Response: the item is taken at the start edge, its result strobes in the next cycle.
// Throughput: one item per cycle; busy stays low, every cell shifts in the same cycle.
// Reset: synchronous; clears all valid bits and the count, no clearing pass.
// The receiver cannot stall; each result is on rsp_* for exactly one cycle.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove #(
   parameter int CAPACITY = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [slir_pkg::CMD_W-1:0]           req_cmd,
   input  logic signed [slir_pkg::DATA_W-1:0]   req_value,
   input  logic [slir_pkg::INDEX_W-1:0]         req_index,
   output logic                                 rsp_valid,
   output logic                                 rsp_ok,
   output logic signed [slir_pkg::DATA_W-1:0]   rsp_read_value,
   output logic [slir_pkg::COUNT_W-1:0]         rsp_count,
   output logic                                 rsp_empty_res,
   output logic                                 rsp_full_res
);

   localparam int CW = $clog2(CAPACITY + 1);

   slir_pkg::cell_ctl_type  ctl;
   slir_pkg::cell_stat_type stat [CAPACITY];
   slir_pkg::cell_stat_type lbound, rbound;

   logic [CW-1:0]               count_ff, count_in;
   logic                        rsp_valid_ff, rsp_ok_ff;
   logic [slir_pkg::DATA_W-1:0] rd_data_ff, rd_data_in;
   logic                        ok_in, found, rd_hit, full;
   logic [CAPACITY-1:0]         valid_vec;

   assign busy = 1'b0;
   assign full = (count_ff == CW'(CAPACITY));

   always_comb begin
      lbound       = '0;
      lbound.valid = 1'b1;
      rbound       = '0;
   end

   always_comb begin
      found      = 1'b0;
      rd_hit     = 1'b0;
      rd_data_in = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         valid_vec[i] = stat[i].valid;
         found        = found | stat[i].hit;
         if (i < 32 && int'(req_index) == i && stat[i].valid) begin
            rd_hit = 1'b1;
            if (req_cmd == slir_pkg::CMD_READ) begin
               rd_data_in = stat[i].entry;
            end
         end
      end
   end

   always_comb begin
      ctl.value  = req_value;
      ctl.do_ins = start && (req_cmd == slir_pkg::CMD_INSERT) && !full;
      ctl.do_rem = start && (req_cmd == slir_pkg::CMD_REMOVE) && found;
      count_in   = count_ff;
      if (ctl.do_ins) begin
         count_in = count_ff + CW'(1);
      end else if (ctl.do_rem) begin
         count_in = count_ff - CW'(1);
      end
      case (req_cmd)
         slir_pkg::CMD_INSERT: ok_in = !full;
         slir_pkg::CMD_REMOVE: ok_in = found;
         slir_pkg::CMD_READ:   ok_in = rd_hit;
         default:              ok_in = 1'b0;
      endcase
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      slir_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctl   (ctl),
         .left  ((g == 0) ? lbound : stat[(g == 0) ? 0 : g - 1]),
         .right ((g == CAPACITY - 1) ? rbound : stat[(g == CAPACITY - 1) ? g : g + 1]),
         .stat  (stat[g])
      );
   end

   always_ff @(posedge clock) begin
      rsp_ok_ff  <= ok_in;
      rd_data_ff <= rd_data_in;
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= start;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_read_value = rd_data_ff;
   assign rsp_count      = slir_pkg::COUNT_W'(count_ff);
   assign rsp_empty_res  = (count_ff == '0);
   assign rsp_full_res   = full;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("count beyond capacity");

   a_valid_match: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("valid bits disagree with count");

   a_ins_count: assert property (@(posedge clock) disable iff (reset)
      start && req_cmd == slir_pkg::CMD_INSERT && !full |=>
         rsp_ok && count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not add an item");

   a_rem_count: assert property (@(posedge clock) disable iff (reset)
      start && req_cmd == slir_pkg::CMD_REMOVE && found |=>
         rsp_ok && count_ff == $past(count_ff) - CW'(1))
      else $error("remove did not drop an item");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the sorted list block
// A table of directed commands runs first: empty list, the value extremes,
// duplicates, absent values, out-of-range reads and the unused command
// code. Random fill, full and drain rounds and a long mixed run follow.
// Each accepted item is run through an ascending-list predictor, and each
// strobed result is compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module testbench;

   localparam int LIST_CAP = 32;
   localparam int DIR_N    = 23;
   localparam int MIX_N    = 450;

   localparam logic [slir_pkg::CMD_W-1:0] CMD_NOP = 2'd3;

   typedef struct packed {
      logic                         ok;
      logic [slir_pkg::DATA_W-1:0]  rd;
      logic [slir_pkg::COUNT_W-1:0] count;
      logic                         empty;
      logic                         full;
   } rsp_item_type;

   typedef struct packed {
      logic [slir_pkg::CMD_W-1:0]   cmd;
      logic [slir_pkg::DATA_W-1:0]  value;
      logic [slir_pkg::INDEX_W-1:0] index;
      logic                         typed;
      rsp_item_type                 want;
   } stim_row_type;

   logic                                clock;
   logic                                reset;
   logic                                start;
   logic                                busy;
   logic [slir_pkg::CMD_W-1:0]          req_cmd;
   logic signed [slir_pkg::DATA_W-1:0]  req_value;
   logic [slir_pkg::INDEX_W-1:0]        req_index;
   logic                                rsp_valid;
   logic                                rsp_ok;
   logic signed [slir_pkg::DATA_W-1:0]  rsp_read_value;
   logic [slir_pkg::COUNT_W-1:0]        rsp_count;
   logic                                rsp_empty_res;
   logic                                rsp_full_res;

   logic signed [slir_pkg::DATA_W-1:0]  list_mem [LIST_CAP];
   int                                  list_len;
   rsp_item_type                        pending_q [$];
   rsp_item_type                        oldest;
   int                                  err_count;
   logic                                burst_mode;

   stim_row_type dir_rows [DIR_N] = '{
      '{slir_pkg::CMD_READ,   32'h0000_0000, 5'd0, 1'b1, '{1'b0, 32'h0000_0000, 6'd0, 1'b1, 1'b0}},
      '{slir_pkg::CMD_REMOVE, 32'h0000_0005, 5'd0, 1'b1, '{1'b0, 32'h0000_0000, 6'd0, 1'b1, 1'b0}},
      '{CMD_NOP,              32'hFFFF_FFFF, 5'd31, 1'b1, '{1'b0, 32'h0, 6'd0, 1'b1, 1'b0}},
      '{slir_pkg::CMD_INSERT, 32'h7FFF_FFFF, 5'd0, 1'b1, '{1'b1, 32'h0000_0000, 6'd1, 1'b0, 1'b0}},
      '{slir_pkg::CMD_INSERT, 32'h8000_0000, 5'd0, 1'b1, '{1'b1, 32'h0000_0000, 6'd2, 1'b0, 1'b0}},
      '{slir_pkg::CMD_INSERT, 32'h0000_0000, 5'd31, 1'b1, '{1'b1, 32'h0, 6'd3, 1'b0, 1'b0}},
      '{slir_pkg::CMD_READ,   32'h0000_0000, 5'd0, 1'b1, '{1'b1, 32'h8000_0000, 6'd3, 1'b0, 1'b0}},
      '{slir_pkg::CMD_READ,   32'hFFFF_FFFF, 5'd2, 1'b1, '{1'b1, 32'h7FFF_FFFF, 6'd3, 1'b0, 1'b0}},
      '{slir_pkg::CMD_READ,   32'h0000_0000, 5'd3, 1'b1, '{1'b0, 32'h0000_0000, 6'd3, 1'b0, 1'b0}},
      '{slir_pkg::CMD_READ,   32'h0000_0000, 5'd31, 1'b1, '{1'b0, 32'h0, 6'd3, 1'b0, 1'b0}},
      '{slir_pkg::CMD_REMOVE, 32'h0000_0001, 5'd0, 1'b1, '{1'b0, 32'h0000_0000, 6'd3, 1'b0, 1'b0}},
      '{slir_pkg::CMD_INSERT, 32'h0000_0000, 5'd0, 1'b0, '0},
      '{slir_pkg::CMD_INSERT, 32'hFFFF_FFFF, 5'd0, 1'b0, '0},
      '{slir_pkg::CMD_READ,   32'h0000_0000, 5'd1, 1'b0, '0},
      '{slir_pkg::CMD_READ,   32'h0000_0000, 5'd2, 1'b0, '0},
      '{slir_pkg::CMD_REMOVE, 32'h0000_0000, 5'd0, 1'b0, '0},
      '{slir_pkg::CMD_REMOVE, 32'h8000_0000, 5'd0, 1'b0, '0},
      '{slir_pkg::CMD_REMOVE, 32'h7FFF_FFFF, 5'd0, 1'b0, '0},
      '{CMD_NOP,              32'h0000_0000, 5'd0, 1'b0, '0},
      '{slir_pkg::CMD_READ,   32'h0000_0000, 5'd0, 1'b0, '0},
      '{slir_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 5'd0, 1'b0, '0},
      '{slir_pkg::CMD_REMOVE, 32'h0000_0000, 5'd0, 1'b0, '0},
      '{slir_pkg::CMD_REMOVE, 32'h0000_0000, 5'd0, 1'b1, '{1'b0, 32'h0000_0000, 6'd0, 1'b1, 1'b0}}
   };

   sorted_list_insert_remove #(
      .CAPACITY(LIST_CAP)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_value      (req_value),
      .req_index      (req_index),
      .rsp_valid      (rsp_valid),
      .rsp_ok         (rsp_ok),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count),
      .rsp_empty_res  (rsp_empty_res),
      .rsp_full_res   (rsp_full_res)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // ascending list: insert after equal entries, remove the first equal one
   task automatic predict_list(input logic [slir_pkg::CMD_W-1:0] cmd,
                               input logic signed [slir_pkg::DATA_W-1:0] v,
                               input logic [slir_pkg::INDEX_W-1:0] idx,
                               output rsp_item_type r);
      int pos;
      int i;
      r = '0;
      case (cmd)
         slir_pkg::CMD_INSERT: begin
            if (list_len < LIST_CAP) begin
               pos = 0;
               while (pos < list_len && !(v < list_mem[pos])) pos++;
               for (i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
               list_mem[pos] = v;
               list_len++;
               r.ok = 1'b1;
            end
         end
         slir_pkg::CMD_REMOVE: begin
            pos = 0;
            while (pos < list_len && list_mem[pos] < v) pos++;
            if (pos < list_len && list_mem[pos] == v) begin
               for (i = pos + 1; i < list_len; i++) list_mem[i-1] = list_mem[i];
               list_len--;
               r.ok = 1'b1;
            end
         end
         slir_pkg::CMD_READ: begin
            if (int'(idx) < list_len) begin
               r.ok = 1'b1;
               r.rd = list_mem[idx];
            end
         end
         default: ;
      endcase
      r.count = list_len[slir_pkg::COUNT_W-1:0];
      r.empty = (list_len == 0);
      r.full  = (list_len == LIST_CAP);
   endtask

   // entered and left at a falling edge
   task automatic send_item(input logic [slir_pkg::CMD_W-1:0] cmd,
                            input logic signed [slir_pkg::DATA_W-1:0] v,
                            input logic [slir_pkg::INDEX_W-1:0] idx, input logic typed,
                            input rsp_item_type typed_want);
      int gap;
      rsp_item_type pred;
      if ($urandom_range(0, 31) == 0) burst_mode = ~burst_mode;
      gap = burst_mode ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start     <= 1'b1;
      req_cmd   <= cmd;
      req_value <= v;
      req_index <= idx;
      do @(posedge clock); while (busy !== 1'b0);
      predict_list(cmd, v, idx, pred);
      pending_q.push_back(typed ? typed_want : pred);
      @(negedge clock);
   endtask

   function automatic logic signed [slir_pkg::DATA_W-1:0] pick_value();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return 32'sh8000_0000;
      if (sel == 1) return 32'sh7FFF_FFFF;
      if (sel < 6) return $signed($urandom_range(0, 16)) - 8;
      return $urandom;
   endfunction

   function automatic logic signed [slir_pkg::DATA_W-1:0] pick_stored();
      if (list_len > 0 && $urandom_range(0, 9) < 7) return list_mem[$urandom_range(0, list_len - 1)];
      return pick_value();
   endfunction

   function automatic logic [slir_pkg::INDEX_W-1:0] pick_index();
      if (list_len > 0 && $urandom_range(0, 9) < 8)
         return slir_pkg::INDEX_W'($urandom_range(0, list_len - 1));
      return slir_pkg::INDEX_W'($urandom_range(0, 31));
   endfunction

   function automatic logic [slir_pkg::INDEX_W-1:0] rand_index();
      return slir_pkg::INDEX_W'($urandom);
   endfunction

   task automatic check_field(input string name, input logic [slir_pkg::DATA_W-1:0] want_v,
                              input logic [slir_pkg::DATA_W-1:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
         err_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid !== 1'b0) begin
         if (pending_q.size() == 0) begin
            $display("%0t: result with none expected, expected none, got ok=%b count=%0d",
                     $time, rsp_ok, rsp_count);
            err_count++;
         end else begin
            oldest = pending_q.pop_front();
            check_field("ok", slir_pkg::DATA_W'(oldest.ok), slir_pkg::DATA_W'(rsp_ok));
            check_field("read_value", oldest.rd, rsp_read_value);
            check_field("count", slir_pkg::DATA_W'(oldest.count),
                        slir_pkg::DATA_W'(rsp_count));
            check_field("empty", slir_pkg::DATA_W'(oldest.empty),
                        slir_pkg::DATA_W'(rsp_empty_res));
            check_field("full", slir_pkg::DATA_W'(oldest.full),
                        slir_pkg::DATA_W'(rsp_full_res));
         end
      end
   end

   initial begin
      int k;
      int round;
      int sel;
      err_count  = 0;
      list_len   = 0;
      burst_mode = 1'b0;
      for (k = 0; k < LIST_CAP; k++) list_mem[k] = '0;
      reset     = 1'b1;
      start     = 1'b0;
      req_cmd   = slir_pkg::CMD_INSERT;
      req_value = '0;
      req_index = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (k = 0; k < DIR_N; k++)
         send_item(dir_rows[k].cmd, dir_rows[k].value, dir_rows[k].index,
                   dir_rows[k].typed, dir_rows[k].want);

      for (round = 0; round < 2; round++) begin
         while (list_len < LIST_CAP) begin
            if ($urandom_range(0, 9) < 2)
               send_item(slir_pkg::CMD_READ, $urandom, pick_index(), 1'b0, '0);
            else send_item(slir_pkg::CMD_INSERT, pick_value(), rand_index(), 1'b0, '0);
         end
         for (k = 0; k < 3; k++)
            send_item(slir_pkg::CMD_INSERT, pick_value(), rand_index(), 1'b0, '0);
         send_item(slir_pkg::CMD_READ, $urandom, 5'd31, 1'b0, '0);
         send_item(slir_pkg::CMD_READ, $urandom, pick_index(), 1'b0, '0);
         send_item(CMD_NOP, $urandom, rand_index(), 1'b0, '0);
         while (list_len > 0) begin
            sel = $urandom_range(0, 9);
            if (sel < 8) send_item(slir_pkg::CMD_REMOVE, pick_stored(), rand_index(), 1'b0, '0);
            else send_item(slir_pkg::CMD_READ, $urandom, pick_index(), 1'b0, '0);
         end
         send_item(slir_pkg::CMD_REMOVE, pick_value(), rand_index(), 1'b0, '0);
      end

      // hold off until the block has drained
      start <= 1'b0;
      while (pending_q.size() != 0) @(negedge clock);

      for (k = 0; k < MIX_N; k++) begin
         sel = $urandom_range(0, 99);
         if (sel < 38) send_item(slir_pkg::CMD_INSERT, pick_value(), rand_index(), 1'b0, '0);
         else if (sel < 70)
            send_item(slir_pkg::CMD_REMOVE, pick_stored(), rand_index(), 1'b0, '0);
         else if (sel < 95) send_item(slir_pkg::CMD_READ, $urandom, pick_index(), 1'b0, '0);
         else send_item(CMD_NOP, $urandom, rand_index(), 1'b0, '0);
      end

      start <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (err_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
